// ----- hw/rtl/packet_domain_name_extractor_assert.svh -----
// Assertion macros for the domain name extractor RTL, included by the back end.
// Depends on nothing; included inside module bodies.
`ifndef PACKET_DOMAIN_NAME_EXTRACTOR_ASSERT_SVH
`define PACKET_DOMAIN_NAME_EXTRACTOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PDNE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PDNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pdne_pkg.sv -----
// Package for the domain name extractor: payload structs, codes, constants.
// Depends on nothing.
`default_nettype none
package pdne_pkg;
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic        source;
    logic [15:0] name_length;
    logic [15:0] frame_bytes;
    logic        run_last;
  } out_item_t;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [1:0] REG_DNS_PORT = 2'd0;
  localparam logic [1:0] REG_WEB_A    = 2'd1;
  localparam logic [1:0] REG_WEB_B    = 2'd2;
  localparam logic [1:0] REG_WEB_C    = 2'd3;

  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam int unsigned DNS_HDR_BYTES = 12;

  localparam logic [47:0] HOST_KEY = 48'h486f73743a20;  // "Host: "

  // Front-to-back command: up to three results caused by one byte.
  typedef struct packed {
    logic [1:0]  cnt;        // results in this command, 1..3
    out_item_t   r0;
    out_item_t   r1;
    out_item_t   r2;
  } cmd_t;

  function automatic logic [7:0] host_key_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0: c = HOST_KEY[47:40];
      3'd1: c = HOST_KEY[39:32];
      3'd2: c = HOST_KEY[31:24];
      3'd3: c = HOST_KEY[23:16];
      3'd4: c = HOST_KEY[15:8];
      3'd5: c = HOST_KEY[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pdne_regs.sv -----
// APB register file holding the port numbers.
// Depends on pdne_pkg.
`default_nettype none
module pdne_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      dns_port_o,
  output logic [15:0]      web_a_o,
  output logic [15:0]      web_b_o,
  output logic [15:0]      web_c_o
);
  import pdne_pkg::*;

  logic [15:0] dns_q, wa_q, wb_q, wc_q;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_q <= 16'd53;
      wa_q  <= 16'd80;
      wb_q  <= 16'd443;
      wc_q  <= 16'd8080;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_DNS_PORT: dns_q <= pwdata[15:0];
        REG_WEB_A:    wa_q  <= pwdata[15:0];
        REG_WEB_B:    wb_q  <= pwdata[15:0];
        REG_WEB_C:    wc_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DNS_PORT: prdata = {16'h0, dns_q};
      REG_WEB_A:    prdata = {16'h0, wa_q};
      REG_WEB_B:    prdata = {16'h0, wb_q};
      REG_WEB_C:    prdata = {16'h0, wc_q};
      default:      prdata = 32'h0;
    endcase
  end

  assign dns_port_o = dns_q;
  assign web_a_o    = wa_q;
  assign web_b_o    = wb_q;
  assign web_c_o    = wc_q;
endmodule
`default_nettype wire

// ----- hw/rtl/pdne_front.sv -----
// Front end: parses frame bytes and turns each into a command of 0..3 results.
// Depends on pdne_pkg.
`default_nettype none
module pdne_front #(
  parameter int unsigned LinkHeaderBytes = 14,
  parameter int unsigned MaxLabel = 63
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire pdne_pkg::in_item_t item_i,
  input  wire logic [15:0]        dns_port_i,
  input  wire logic [15:0]        web_a_i,
  input  wire logic [15:0]        web_b_i,
  input  wire logic [15:0]        web_c_i,
  output logic                    cmd_vld_o,
  output pdne_pkg::cmd_t          cmd_o
);
  import pdne_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_IGNORE, PH_DNS_LEN, PH_DNS_LABEL,
    PH_HTTP_FIRST, PH_HTTP_SEARCH, PH_HTTP_HOST, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {TK_NONE, TK_UDP, TK_TCP} tk_e;

  localparam logic [15:0] IpOff = 16'(LinkHeaderBytes);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  hw_q, hw_d;
  tk_e         tk_q, tk_d;
  logic [15:0] sp_q, sp_d, dp_q, dp_d;
  logic [3:0]  thw_q, thw_d;
  phase_e      ph_q, ph_d;
  logic [5:0]  lr_q, lr_d;
  logic        fl_q, fl_d;
  logic [2:0]  mi_q, mi_d;
  logic        hr_q, hr_d;
  logic        cs_q, cs_d;
  logic [15:0] nc_q, nc_d;

  logic [7:0]  b;
  logic [16:0] tpos;
  logic [16:0] rel;
  logic        in_tp;
  logic [1:0]  n;
  out_item_t   r [3];
  logic        src;
  logic [5:0]  thw_end;
  logic        ok;

  assign b    = item_i.frame_byte;
  assign src  = (tk_q == TK_TCP);
  assign tpos = {1'b0, IpOff} + {11'd0, hw_q, 2'b00};
  assign rel  = {1'b0, pos_q} - tpos;
  assign in_tp = ({1'b0, pos_q} >= tpos);
  assign thw_end = {thw_q, 2'b00} - 6'd1;

  always_comb begin
    out_item_t ch;
    logic      match;
    pos_d = pos_q; hw_d = hw_q; tk_d = tk_q; sp_d = sp_q; dp_d = dp_q;
    thw_d = thw_q; ph_d = ph_q; lr_d = lr_q; fl_d = fl_q; mi_d = mi_q;
    hr_d = hr_q; cs_d = cs_q; nc_d = nc_q;
    n = 2'd0;
    ch = '0;
    match = 1'b0;
    for (int k = 0; k < 3; k++) r[k] = '0;

    unique case (ph_q)
      PH_HDR: begin
        if (pos_q == IpOff) begin
          hw_d = b[3:0];
          if (b[7:4] != 4'd4 || b[3:0] < 4'd5) ph_d = PH_IGNORE;
        end else if (pos_q == IpOff + 16'd9) begin
          if (b == PROTO_UDP) tk_d = TK_UDP;
          else if (b == PROTO_TCP) tk_d = TK_TCP;
          else ph_d = PH_IGNORE;
        end else if (tk_q != TK_NONE && in_tp) begin
          if (rel == 17'd0) sp_d = {b, 8'h00};
          else if (rel == 17'd1) sp_d = {sp_q[15:8], b};
          else if (rel == 17'd2) dp_d = {b, 8'h00};
          else if (rel == 17'd3) begin
            dp_d = {dp_q[15:8], b};
            if (tk_q == TK_UDP) begin
              if (sp_q != dns_port_i && dp_d != dns_port_i) ph_d = PH_IGNORE;
            end else if (dp_d != web_a_i && dp_d != web_b_i && dp_d != web_c_i) begin
              ph_d = PH_IGNORE;
            end
          end
          if (tk_q == TK_UDP) begin
            if (rel == 17'(8 + DNS_HDR_BYTES - 1)) ph_d = PH_DNS_LEN;
          end else begin
            if (rel == 17'd12) begin
              thw_d = b[7:4];
              if (b[7:4] < 4'd5) ph_d = PH_IGNORE;
            end else if (rel > 17'd12 && rel == {11'd0, thw_end}) begin
              ph_d = PH_HTTP_FIRST;
            end
          end
        end
      end
      PH_DNS_LEN: begin
        if (b == 8'd0) ph_d = PH_DONE;
        else if ({24'd0, b} > MaxLabel) ph_d = PH_IGNORE;
        else begin
          if (!fl_q) begin
            if (nc_d != 16'hffff) nc_d = nc_d + 16'd1;
            r[0] = '{kind: KIND_CHAR, name_char: CH_DOT, source: src,
                     name_length: nc_d, frame_bytes: 16'd0, run_last: 1'b0};
            n = 2'd1;
          end
          fl_d = 1'b0;
          lr_d = b[5:0];
          ph_d = PH_DNS_LABEL;
        end
      end
      PH_DNS_LABEL: begin
        if (nc_d != 16'hffff) nc_d = nc_d + 16'd1;
        r[0] = '{kind: KIND_CHAR, name_char: b, source: src,
                 name_length: nc_d, frame_bytes: 16'd0, run_last: 1'b0};
        n = 2'd1;
        if (lr_q != 6'd0) lr_d = lr_q - 6'd1;
        if (lr_d == 6'd0) ph_d = PH_DNS_LEN;
      end
      PH_HTTP_FIRST, PH_HTTP_SEARCH: begin
        if (ph_q == PH_HTTP_FIRST && b != CH_G && b != CH_P && b != CH_H) begin
          ph_d = PH_IGNORE;
        end else begin
          ph_d = PH_HTTP_SEARCH;
          match = (mi_q < 3'd6) && (b == host_key_char(mi_q));
          if (match) begin
            if (mi_q == 3'd5) begin
              mi_d = 3'd0;
              ph_d = PH_HTTP_HOST;
            end else begin
              mi_d = mi_q + 3'd1;
            end
          end else begin
            mi_d = (b == CH_H) ? 3'd1 : 3'd0;
          end
        end
      end
      PH_HTTP_HOST: begin
        if (hr_q && b == CH_LF) begin
          hr_d = 1'b0;
          ph_d = PH_DONE;
        end else begin
          if (hr_q) begin
            hr_d = 1'b0;
            if (!cs_q) begin
              if (nc_d != 16'hffff) nc_d = nc_d + 16'd1;
              r[0] = '{kind: KIND_CHAR, name_char: CH_CR, source: src,
                       name_length: nc_d, frame_bytes: 16'd0, run_last: 1'b0};
              n = 2'd1;
            end
          end
          if (b == CH_CR) hr_d = 1'b1;
          else if (cs_q) begin
          end else if (b == CH_COLON) cs_d = 1'b1;
          else begin
            if (nc_d != 16'hffff) nc_d = nc_d + 16'd1;
            ch = '{kind: KIND_CHAR, name_char: b, source: src,
                   name_length: nc_d, frame_bytes: 16'd0, run_last: 1'b0};
            r[n] = ch;
            n = n + 2'd1;
          end
        end
      end
      default: ;
    endcase

    if (pos_q != 16'hffff) pos_d = pos_q + 16'd1;

    ok = 1'b0;
    if (item_i.frame_end) begin
      ok = (nc_d != 16'd0) && (ph_d == PH_DONE ||
           (tk_d == TK_UDP && (ph_d == PH_DNS_LEN || ph_d == PH_DNS_LABEL)));
      if (ok) r[n] = '{kind: KIND_FOUND, name_char: 8'd0, source: (tk_d == TK_TCP),
                       name_length: nc_d, frame_bytes: pos_d, run_last: 1'b0};
      else    r[n] = '{kind: KIND_NONE, name_char: 8'd0, source: 1'b0,
                       name_length: 16'd0, frame_bytes: pos_d, run_last: 1'b0};
      n = n + 2'd1;
      pos_d = '0; hw_d = '0; tk_d = TK_NONE; sp_d = '0; dp_d = '0; thw_d = '0;
      ph_d = PH_HDR; lr_d = '0; fl_d = 1'b1; mi_d = '0; hr_d = 1'b0;
      cs_d = 1'b0; nc_d = '0;
    end
    if (n != 2'd0) r[n - 2'd1].run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hw_q <= '0; tk_q <= TK_NONE; sp_q <= '0; dp_q <= '0;
      thw_q <= '0; ph_q <= PH_HDR; lr_q <= '0; fl_q <= 1'b1; mi_q <= '0;
      hr_q <= 1'b0; cs_q <= 1'b0; nc_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d; hw_q <= hw_d; tk_q <= tk_d; sp_q <= sp_d; dp_q <= dp_d;
      thw_q <= thw_d; ph_q <= ph_d; lr_q <= lr_d; fl_q <= fl_d; mi_q <= mi_d;
      hr_q <= hr_d; cs_q <= cs_d; nc_q <= nc_d;
    end
  end

  assign cmd_vld_o       = step_i && (n != 2'd0);
  assign cmd_o.cnt       = n;
  assign cmd_o.r0        = r[0];
  assign cmd_o.r1        = r[1];
  assign cmd_o.r2        = r[2];
endmodule
`default_nettype wire

// ----- hw/rtl/pdne_back.sv -----
// Back end: command queue and serializer that hands out one result per pop.
// Depends on pdne_pkg and the assertion macro header.
`default_nettype none
module pdne_back #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_vld_i,
  input  wire pdne_pkg::cmd_t   cmd_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output pdne_pkg::out_item_t   item_o
);
  import pdne_pkg::*;
  `include "packet_domain_name_extractor_assert.svh"

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic [1:0]      sub_q;
  logic            push, pop_cmd, take;
  cmd_t            head;

  assign head    = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign push    = cmd_vld_i;
  assign take    = pop_i && !empty_o;
  assign pop_cmd = take && (sub_q == head.cnt - 2'd1);

  always_comb begin
    unique case (sub_q)
      2'd0:    item_o = head.r0;
      2'd1:    item_o = head.r1;
      default: item_o = head.r2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_cmd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      // advance within a command, wrap to the next on its last result
      if (take) sub_q <= pop_cmd ? 2'd0 : sub_q + 2'd1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop_cmd);
    end
  end

  `PDNE_ASSERT(a_no_overflow, push, !full_o, "command pushed into full queue")
  `PDNE_ASSERT(a_sub_in_range, !empty_o, sub_q < head.cnt, "result index past command")
  `PDNE_ASSERT(a_last_flag, take, item_o.run_last == pop_cmd, "run_last mismatch")
  `PDNE_ASSERT_NEXT(a_cnt_track, push && !pop_cmd, cnt_q == $past(cnt_q) + 1'b1,
                    "occupancy not advanced")
endmodule
`default_nettype wire

// ----- hw/rtl/packet_domain_name_extractor.sv -----
// Domain name extractor for a byte stream of Ethernet frames.
// Channels: input queue (push/full) taking one frame byte and a last-byte flag per
// transfer; output queue (empty/pop) giving name characters and one verdict per frame.
// Config: APB port with four 16-bit port registers at byte addresses 0,4,8,12.
// Throughput: one byte per cycle while full is low. Each byte is parsed in the cycle
// it is taken; its 0..3 results enter a four-entry command queue as one command, and
// its first result is on the output once that command reaches the head. The output
// side hands out one result per cycle while pop is high, so a byte that causes two
// or three results (host CR plus char, char plus verdict) needs that many pops; the
// queue absorbs such bytes and full rises only when four commands wait.
// Stall: when pop stays low the queue fills and full rises; bytes are held
// upstream, nothing is dropped.
// Reset: clears the parser to the start of a frame, empties the queue and loads
// the port registers with 53, 80, 443 and 8080.
// A none verdict tells the receiver to discard the characters of that frame.
`default_nettype none
module packet_domain_name_extractor #(
  parameter int unsigned LINK_HEADER_BYTES = 14,
  parameter int unsigned MAX_LABEL = 63
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire pdne_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output pdne_pkg::out_item_t      out_item_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import pdne_pkg::*;

  logic [15:0] dns_port, web_a, web_b, web_c;
  logic        cmd_vld, q_full, step;
  cmd_t        cmd;

  assign full = q_full;
  assign step = push && !q_full;

  pdne_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .dns_port_o(dns_port), .web_a_o(web_a), .web_b_o(web_b), .web_c_o(web_c)
  );

  pdne_front #(.LinkHeaderBytes(LINK_HEADER_BYTES), .MaxLabel(MAX_LABEL)) u_front (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_item_i),
    .dns_port_i(dns_port), .web_a_i(web_a), .web_b_i(web_b), .web_c_i(web_c),
    .cmd_vld_o(cmd_vld), .cmd_o(cmd)
  );

  pdne_back #(.Depth(4)) u_back (
    .clk_i, .rst_ni, .cmd_vld_i(cmd_vld), .cmd_i(cmd), .full_o(q_full),
    .empty_o(empty), .pop_i(pop), .item_o(out_item_o)
  );
endmodule
`default_nettype wire
